// File: hw/rtl/ugsh_pkg.sv
package ugsh_pkg;

    localparam int NUM_CELLS_DEF     = 1024;
    localparam int CELL_CAPACITY_DEF = 16;
    localparam int CORNERS           = 4;
    localparam int COORD_W           = 16;
    localparam int ID_W              = 16;
    localparam int DIM_W             = 11;
    localparam int CSIZE_W           = 16;
    localparam int QUO_W             = COORD_W + 1;
    localparam int FILL_W            = 5;
    localparam int QUEUE_DEPTH       = 2;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    localparam logic [1:0] REG_COLS  = 2'd0;
    localparam logic [1:0] REG_ROWS  = 2'd1;
    localparam logic [1:0] REG_CSIZE = 2'd2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// File: hw/rtl/ugsh_queue.sv
module ugsh_queue import ugsh_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output t_qstat       o_stat
);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// File: hw/rtl/ugsh_front.sv
module ugsh_front import ugsh_pkg::*; #(
    parameter int NUM_CELLS = NUM_CELLS_DEF,
    parameter int ENT_W     = 2 + 3 + CORNERS * $clog2(NUM_CELLS) + ID_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_init,
    output logic               o_busy,
    input  logic [1:0]         i_action,
    input  logic [COORD_W-1:0] i_box_x,
    input  logic [COORD_W-1:0] i_box_y,
    input  logic [COORD_W-1:0] i_box_width,
    input  logic [COORD_W-1:0] i_box_height,
    input  logic [ID_W-1:0]    i_item_id,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [CSIZE_W-1:0] i_cfg_data,
    input  t_qstat             i_qstat,
    output logic               o_push,
    output logic [ENT_W-1:0]   o_push_data
);
    localparam int CW  = $clog2(NUM_CELLS);
    localparam int CNW = $clog2(NUM_CELLS + 1);
    localparam int PRW = QUO_W + DIM_W;

    typedef struct packed {
        logic [1:0]                  act;
        logic [2:0]                  n;
        logic [CORNERS-1:0][CW-1:0]  cells;
        logic [ID_W-1:0]             id;
    } t_ent;

    typedef enum logic [2:0] {F_IDLE, F_DIV, F_MUL, F_CHK, F_PUSH} t_fstate;

    t_fstate                 r_state;
    logic [DIM_W-1:0]        r_cols, r_rows;
    logic [CSIZE_W-1:0]      r_csize;
    logic [CNW-1:0]          r_cnt;
    logic [1:0]              r_act;
    logic [ID_W-1:0]         r_id;
    logic [QUO_W-1:0]        r_dvd [CORNERS];
    logic [QUO_W-1:0]        r_q   [CORNERS];
    logic [QUO_W-1:0]        r_dq;
    logic [CSIZE_W-1:0]      r_rem;
    logic [1:0]              r_k;
    logic [4:0]              r_bit;
    logic [PRW-1:0]          r_prod;
    logic [CW-1:0]           r_cells [CORNERS];
    logic [2:0]              r_n;

    logic [CSIZE_W-1:0]      cs;
    logic [QUO_W-1:0]        trial;
    logic                    ge;
    logic [QUO_W-1:0]        qx, qy;
    logic [PRW:0]            idx;
    logic                    in_grid, dup;
    logic [2*DIM_W-1:0]      area;
    logic                    accept;
    t_ent                    ent;

    assign cs     = (r_csize == '0) ? CSIZE_W'(1) : r_csize;
    assign trial  = {r_rem, r_dq[QUO_W-1]};
    assign ge     = trial >= {1'b0, cs};
    assign qx     = (r_k == 2'd1 || r_k == 2'd2) ? r_q[1] : r_q[0];
    assign qy     = r_k[1] ? r_q[3] : r_q[2];
    assign idx    = {1'b0, r_prod} + (PRW + 1)'(qx);
    assign in_grid = idx < (PRW + 1)'(r_cnt);
    assign area   = (2*DIM_W)'(r_cols) * (2*DIM_W)'(r_rows);
    assign o_busy = (r_state != F_IDLE) || i_init;
    assign accept = i_start && !o_busy;
    assign o_push = (r_state == F_PUSH) && !i_qstat.full;

    always_comb begin
        dup = 1'b0;
        for (int k = 0; k < CORNERS; k++) begin
            if (3'(k) < r_n && r_cells[k] == idx[CW-1:0]) begin
                dup = 1'b1;
            end
        end
        ent.act = r_act;
        ent.n   = r_n;
        ent.id  = r_id;
        for (int k = 0; k < CORNERS; k++) begin
            ent.cells[k] = r_cells[k];
        end
        o_push_data = ent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cols  <= DIM_W'(32);
            r_rows  <= DIM_W'(32);
            r_csize <= CSIZE_W'(32);
            r_cnt   <= '0;
        end else begin
            if (32'(area) > 32'(NUM_CELLS)) begin
                r_cnt <= CNW'(NUM_CELLS);
            end else begin
                r_cnt <= CNW'(area);
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_COLS:  r_cols  <= i_cfg_data[DIM_W-1:0];
                    REG_ROWS:  r_rows  <= i_cfg_data[DIM_W-1:0];
                    REG_CSIZE: r_csize <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_act    <= i_action;
                        r_id     <= i_item_id;
                        r_dvd[0] <= QUO_W'(i_box_x);
                        r_dvd[1] <= QUO_W'(i_box_x) + QUO_W'(i_box_width);
                        r_dvd[2] <= QUO_W'(i_box_y);
                        r_dvd[3] <= QUO_W'(i_box_y) + QUO_W'(i_box_height);
                        r_dq     <= QUO_W'(i_box_x);
                        r_rem    <= '0;
                        r_k      <= '0;
                        r_bit    <= '0;
                        r_n      <= '0;
                        if (i_action == ACT_INSERT || i_action == ACT_QUERY) begin
                            r_state <= F_DIV;
                        end else begin
                            r_state <= F_PUSH;
                        end
                    end
                end
                F_DIV: begin
                    if (r_bit == 5'(QUO_W - 1)) begin
                        r_q[r_k] <= {r_dq[QUO_W-2:0], ge};
                        r_rem    <= '0;
                        r_bit    <= '0;
                        if (r_k == 2'(CORNERS - 1)) begin
                            r_k     <= '0;
                            r_state <= F_MUL;
                        end else begin
                            r_k  <= r_k + 1'b1;
                            r_dq <= r_dvd[r_k + 1'b1];
                        end
                    end else begin
                        r_rem <= ge ? CSIZE_W'(trial - {1'b0, cs}) : trial[CSIZE_W-1:0];
                        r_dq  <= {r_dq[QUO_W-2:0], ge};
                        r_bit <= r_bit + 1'b1;
                    end
                end
                F_MUL: begin
                    r_prod  <= PRW'(qy) * PRW'(r_cols);
                    r_state <= F_CHK;
                end
                F_CHK: begin
                    if (in_grid && !dup) begin
                        r_cells[r_n[1:0]] <= idx[CW-1:0];
                        r_n               <= r_n + 1'b1;
                    end
                    if (r_k == 2'(CORNERS - 1)) begin
                        r_state <= F_PUSH;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= F_MUL;
                    end
                end
                F_PUSH: begin
                    if (!i_qstat.full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/ugsh_back.sv
module ugsh_back import ugsh_pkg::*; #(
    parameter int NUM_CELLS     = NUM_CELLS_DEF,
    parameter int CELL_CAPACITY = CELL_CAPACITY_DEF,
    parameter int ENT_W         = 2 + 3 + CORNERS * $clog2(NUM_CELLS) + ID_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_qstat           i_qstat,
    input  logic [ENT_W-1:0] i_data,
    output logic             o_pop,
    output logic             o_init,
    output logic             o_strobe,
    output logic [ID_W-1:0]  o_found_id,
    output logic             o_valid_res,
    output logic             o_added,
    output logic             o_overflow,
    output logic             o_last
);
    localparam int CW = $clog2(NUM_CELLS);
    localparam int MW = $clog2(NUM_CELLS * CELL_CAPACITY);

    typedef struct packed {
        logic [1:0]                  act;
        logic [2:0]                  n;
        logic [CORNERS-1:0][CW-1:0]  cells;
        logic [ID_W-1:0]             id;
    } t_ent;

    typedef enum logic [2:0] {B_SWEEP, B_IDLE, B_RDF, B_FV, B_RDM, B_MV, B_FIN} t_bstate;

    logic [FILL_W-1:0] fill_mem [NUM_CELLS];
    logic [ID_W-1:0]   memb_mem [NUM_CELLS * CELL_CAPACITY];

    t_bstate           r_state;
    logic              r_init;
    logic [CW-1:0]     r_sw;
    logic              r_clr_ack;
    t_ent              r_ent;
    logic [2:0]        r_slot;
    logic [FILL_W-1:0] r_j, r_fill;
    logic              r_ovf;
    logic              r_pend_v;
    logic [ID_W-1:0]   r_pend_id;
    logic [FILL_W-1:0] r_fill_q;
    logic [ID_W-1:0]   r_memb_q;
    logic              r_strobe, r_valid, r_added, r_ovf_o, r_last;
    logic [ID_W-1:0]   r_id;

    t_ent              ent_in;
    logic [CW-1:0]     cur;
    logic              room;
    logic              f_we, m_we;
    logic [CW-1:0]     f_waddr;
    logic [FILL_W-1:0] f_wdata;
    logic [MW-1:0]     m_waddr, m_raddr;

    assign ent_in  = i_data;
    assign cur     = r_ent.cells[r_slot[1:0]];
    assign room    = r_fill_q < FILL_W'(CELL_CAPACITY);
    assign o_pop   = (r_state == B_IDLE) && !i_qstat.empty;
    assign o_init  = r_init;
    assign m_we    = (r_state == B_FV) && (r_ent.act == ACT_INSERT) && room;
    assign f_we    = (r_state == B_SWEEP) || m_we;
    assign f_waddr = (r_state == B_SWEEP) ? r_sw : cur;
    assign f_wdata = (r_state == B_SWEEP) ? '0 : r_fill_q + 1'b1;
    assign m_waddr = MW'(cur) * MW'(CELL_CAPACITY) + MW'(r_fill_q);
    assign m_raddr = MW'(cur) * MW'(CELL_CAPACITY) + MW'(r_j);

    assign o_strobe    = r_strobe;
    assign o_found_id  = r_id;
    assign o_valid_res = r_valid;
    assign o_added     = r_added;
    assign o_overflow  = r_ovf_o;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            fill_mem[f_waddr] <= f_wdata;
        end
        r_fill_q <= fill_mem[cur];
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            memb_mem[m_waddr] <= r_ent.id;
        end
        r_memb_q <= memb_mem[m_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_SWEEP;
            r_init    <= 1'b1;
            r_sw      <= '0;
            r_clr_ack <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                B_SWEEP: begin
                    r_sw <= r_sw + 1'b1;
                    if (r_sw == CW'(NUM_CELLS - 1)) begin
                        r_state   <= B_IDLE;
                        r_init    <= 1'b0;
                        r_clr_ack <= 1'b0;
                        if (r_clr_ack) begin
                            r_strobe <= 1'b1;
                            r_id     <= '0;
                            r_valid  <= 1'b0;
                            r_added  <= 1'b0;
                            r_ovf_o  <= 1'b0;
                            r_last   <= 1'b1;
                        end
                    end
                end
                B_IDLE: begin
                    if (o_pop) begin
                        r_ent    <= ent_in;
                        r_slot   <= '0;
                        r_ovf    <= 1'b0;
                        r_pend_v <= 1'b0;
                        unique case (ent_in.act) inside
                            ACT_CLEAR: begin
                                r_sw      <= '0;
                                r_clr_ack <= 1'b1;
                                r_state   <= B_SWEEP;
                            end
                            ACT_INSERT, ACT_QUERY: r_state <= B_RDF;
                            default: begin
                                r_strobe <= 1'b1;
                                r_id     <= '0;
                                r_valid  <= 1'b0;
                                r_added  <= 1'b0;
                                r_ovf_o  <= 1'b0;
                                r_last   <= 1'b1;
                            end
                        endcase
                    end
                end
                B_RDF: begin
                    r_state <= (r_slot == r_ent.n) ? B_FIN : B_FV;
                end
                B_FV: begin
                    if (r_ent.act == ACT_INSERT) begin
                        if (!room) begin
                            r_ovf <= 1'b1;
                        end
                        r_slot  <= r_slot + 1'b1;
                        r_state <= B_RDF;
                    end else begin
                        r_fill <= r_fill_q;
                        r_j    <= '0;
                        if (r_fill_q == '0) begin
                            r_slot  <= r_slot + 1'b1;
                            r_state <= B_RDF;
                        end else begin
                            r_state <= B_RDM;
                        end
                    end
                end
                B_RDM: begin
                    r_state <= B_MV;
                end
                B_MV: begin
                    if (r_pend_v) begin
                        r_strobe <= 1'b1;
                        r_id     <= r_pend_id;
                        r_valid  <= 1'b1;
                        r_added  <= 1'b0;
                        r_ovf_o  <= 1'b0;
                        r_last   <= 1'b0;
                    end
                    r_pend_id <= r_memb_q;
                    r_pend_v  <= 1'b1;
                    r_j       <= r_j + 1'b1;
                    if (r_j + 1'b1 == r_fill) begin
                        r_slot  <= r_slot + 1'b1;
                        r_state <= B_RDF;
                    end else begin
                        r_state <= B_RDM;
                    end
                end
                B_FIN: begin
                    r_strobe <= 1'b1;
                    r_last   <= 1'b1;
                    if (r_ent.act == ACT_INSERT) begin
                        r_id    <= '0;
                        r_valid <= 1'b0;
                        r_added <= (r_ent.n != '0);
                        r_ovf_o <= r_ovf;
                    end else begin
                        r_id    <= r_pend_v ? r_pend_id : '0;
                        r_valid <= r_pend_v;
                        r_added <= 1'b0;
                        r_ovf_o <= 1'b0;
                    end
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/uniform_grid_spatial_hash.sv
// Grid spatial hash: a request is taken when start is high and busy is low, and every result
// appears on the output ports for exactly one cycle with o_res_strobe high; the receiver cannot
// stall, so it must take each result as it comes. A clear yields one result, an insert one, a
// none action one, and a query one result per stored id of the box's cells (the last one marked)
// or a single empty result. The front end runs four one-bit-per-cycle divisions of the corner
// coordinates by the cell size and then the cell indexing, and busy stays high through both on
// an insert or query. The back end then reads the fill counter of each corner cell and, on a
// query, each stored id; a two-entry queue lets the front end work on the next request meanwhile.
// A clear sweeps all NUM_CELLS fill counters, one per cycle; after reset the same sweep runs
// while busy is held high. Configuration writes are always ready.
module uniform_grid_spatial_hash import ugsh_pkg::*; #(
    parameter int NUM_CELLS     = NUM_CELLS_DEF,
    parameter int CELL_CAPACITY = CELL_CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic [COORD_W-1:0] i_box_x,
    input  logic [COORD_W-1:0] i_box_y,
    input  logic [COORD_W-1:0] i_box_width,
    input  logic [COORD_W-1:0] i_box_height,
    input  logic [ID_W-1:0]    i_item_id,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [CSIZE_W-1:0] i_cfg_data,
    output logic               o_res_strobe,
    output logic [ID_W-1:0]    o_found_id,
    output logic               o_valid_res,
    output logic               o_added,
    output logic               o_overflow,
    output logic               o_last
);
    localparam int ENT_W = 2 + 3 + CORNERS * $clog2(NUM_CELLS) + ID_W;

    logic             push, pop, init;
    logic [ENT_W-1:0] push_data, pop_data;
    t_qstat           qstat;

    assign o_cfg_ready = 1'b1;

    ugsh_front #(.NUM_CELLS(NUM_CELLS), .ENT_W(ENT_W)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_init       (init),
        .o_busy       (busy),
        .i_action     (i_action),
        .i_box_x      (i_box_x),
        .i_box_y      (i_box_y),
        .i_box_width  (i_box_width),
        .i_box_height (i_box_height),
        .i_item_id    (i_item_id),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_qstat      (qstat),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    ugsh_queue #(.W(ENT_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_stat  (qstat)
    );

    ugsh_back #(
        .NUM_CELLS     (NUM_CELLS),
        .CELL_CAPACITY (CELL_CAPACITY),
        .ENT_W         (ENT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (qstat),
        .i_data      (pop_data),
        .o_pop       (pop),
        .o_init      (init),
        .o_strobe    (o_res_strobe),
        .o_found_id  (o_found_id),
        .o_valid_res (o_valid_res),
        .o_added     (o_added),
        .o_overflow  (o_overflow),
        .o_last      (o_last)
    );
endmodule
